// File: src/cptr_pkg.sv
// cptr_pkg: shared types and constants of the camera pixel to rgb888 converter
// payload structs of both channels, format codes, bt.601 coefficients
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cptr_pkg;

   // input transaction: one pixel read
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic       odd_column;
   } pixel_in_type;

   // result transaction: one rgb888 pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_out_type;

   // pixel_format codes
   localparam logic FMT_RGB888  = 1'b0;
   localparam logic FMT_UYVY422 = 1'b1;

   // width of the signed channel sums, covers the full coefficient range
   localparam int SUM_W = 20;

   localparam logic [7:0]               LUMA_BLACK = 8'd16;
   localparam logic signed [8:0]        CHROMA_MID = 9'sd128;
   localparam logic signed [SUM_W-1:0]  COEF_LUMA  = 20'sd298;
   localparam logic signed [SUM_W-1:0]  COEF_R_V   = 20'sd409;
   localparam logic signed [SUM_W-1:0]  COEF_G_U   = 20'sd100;
   localparam logic signed [SUM_W-1:0]  COEF_G_V   = 20'sd208;
   localparam logic signed [SUM_W-1:0]  COEF_B_U   = 20'sd516;
   localparam logic signed [SUM_W-1:0]  ROUND_BIAS = 20'sd128;
   localparam int                       FRAC_BITS  = 8;
   localparam logic [7:0]               CHAN_MAX   = 8'd255;

   // floor shift by FRAC_BITS, then clamp to 0..CHAN_MAX
   function automatic logic [7:0] sat_channel(input logic signed [SUM_W-1:0] sum);
      logic [7:0] res;
      if (sum[SUM_W-1]) begin
         res = 8'd0;
      end else if (|sum[SUM_W-2:FRAC_BITS+8]) begin
         res = CHAN_MAX;
      end else begin
         res = sum[FRAC_BITS+7:FRAC_BITS];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: src/cptr_convert.sv
// cptr_convert: combinational pixel conversion, rgb888 pass-through or
// bt.601 limited-range ycbcr to rgb; depends on cptr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cptr_convert (
   input  wire logic                    pixel_format,
   input  wire cptr_pkg::pixel_in_type  pix_in,
   output cptr_pkg::pixel_out_type      pix_out
);

   logic [7:0]                         y_sel;
   logic [7:0]                         luma;
   logic signed [8:0]                  u;
   logic signed [8:0]                  v;
   logic signed [cptr_pkg::SUM_W-1:0]  luma_x;
   logic signed [cptr_pkg::SUM_W-1:0]  u_x;
   logic signed [cptr_pkg::SUM_W-1:0]  v_x;
   logic signed [cptr_pkg::SUM_W-1:0]  base;
   logic signed [cptr_pkg::SUM_W-1:0]  sum_r;
   logic signed [cptr_pkg::SUM_W-1:0]  sum_g;
   logic signed [cptr_pkg::SUM_W-1:0]  sum_b;

   always_comb begin
      y_sel = pix_in.odd_column ? pix_in.byte3 : pix_in.byte1;
      // black level floor
      luma  = (y_sel >= cptr_pkg::LUMA_BLACK) ? (y_sel - cptr_pkg::LUMA_BLACK) : 8'd0;
      u     = $signed({1'b0, pix_in.byte0}) - cptr_pkg::CHROMA_MID;
      v     = $signed({1'b0, pix_in.byte2}) - cptr_pkg::CHROMA_MID;

      luma_x = $signed({{(cptr_pkg::SUM_W-8){1'b0}}, luma});
      u_x    = $signed({{(cptr_pkg::SUM_W-9){u[8]}}, u});
      v_x    = $signed({{(cptr_pkg::SUM_W-9){v[8]}}, v});

      base  = luma_x * cptr_pkg::COEF_LUMA + cptr_pkg::ROUND_BIAS;
      sum_r = base + v_x * cptr_pkg::COEF_R_V;
      sum_g = base - u_x * cptr_pkg::COEF_G_U - v_x * cptr_pkg::COEF_G_V;
      sum_b = base + u_x * cptr_pkg::COEF_B_U;

      if (pixel_format == cptr_pkg::FMT_RGB888) begin
         pix_out.red   = pix_in.byte0;
         pix_out.green = pix_in.byte1;
         pix_out.blue  = pix_in.byte2;
      end else begin
         pix_out.red   = cptr_pkg::sat_channel(sum_r);
         pix_out.green = cptr_pkg::sat_channel(sum_g);
         pix_out.blue  = cptr_pkg::sat_channel(sum_b);
      end
   end

endmodule

`default_nettype wire

// File: src/camera_pixel_to_rgb888_top.sv
// camera_pixel_to_rgb888_top: top level of the camera pixel to rgb888 converter
// input register, pixel_format register and result register around cptr_convert;
// depends on cptr_pkg and cptr_convert
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                        payload           handshake
// req       req_valid req_stall req_data pixel_in_type     valid & !stall
// rsp       rsp_valid rsp_stall rsp_data pixel_out_type    valid & !stall
// csr       csr_valid csr_ready csr_data pixel_format bit  valid & ready
//
// one transaction per clock sustained while rsp is not stalled; each pixel passes from
// acceptance to result through the input register and then the result register.
// the conversion is a single combinational pass of constant multiply-adds.
// synchronous active-high reset empties both stages and sets rgb888 format.
// a stalled result holds in the result register while the input register still
// fills; req_stall rises only when both stages hold a transaction and rsp is stalled.

module camera_pixel_to_rgb888_top (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire cptr_pkg::pixel_in_type  req_data,

   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output cptr_pkg::pixel_out_type      rsp_data,

   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic                    csr_data
);

   // configuration register
   logic                       format_ff;
   logic                       format_in;

   // input stage
   logic                       in_valid_ff;
   logic                       in_valid_in;
   cptr_pkg::pixel_in_type     in_data_ff;

   // result stage
   logic                       out_valid_ff;
   logic                       out_valid_in;
   cptr_pkg::pixel_out_type    out_data_ff;

   cptr_pkg::pixel_out_type    conv_out;
   logic                       out_advance;
   logic                       in_advance;

   // csr writes always land at once
   assign csr_ready = 1'b1;
   assign format_in = (csr_valid && csr_ready) ? csr_data : format_ff;

   // result register loads when empty or being taken this cycle
   assign out_advance = !out_valid_ff || !rsp_stall;
   // input register loads when empty or its contents move forward
   assign in_advance  = !in_valid_ff || out_advance;

   assign req_stall    = !in_advance;
   assign in_valid_in  = in_advance ? req_valid : in_valid_ff;
   assign out_valid_in = out_advance ? in_valid_ff : out_valid_ff;

   cptr_convert u_convert (
      .pixel_format (format_ff),
      .pix_in       (in_data_ff),
      .pix_out      (conv_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= cptr_pkg::FMT_RGB888;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (in_advance && req_valid) begin
         in_data_ff <= req_data;
      end
      if (out_advance && in_valid_ff) begin
         out_data_ff <= conv_out;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
